// ----- hdl/arwc_pkg.sv -----
package arwc_pkg;

  localparam int LEN_W    = 4;
  localparam int WINDOW_W = 16;
  localparam int CFG_W    = 16;
  localparam int INDEX_W  = 3;
  localparam int LOW_W    = 64;
  localparam int HIGH_W   = 32;
  localparam int CTR_W    = LOW_W + HIGH_W;
  localparam int CTR_BYTES = CTR_W / 8;
  localparam int STATUS_W = 2;

  localparam logic [INDEX_W-1:0] REG_SEQ_FIELD_PRESENT = 3'd0;
  localparam logic [INDEX_W-1:0] REG_SEQ_LEN_BYTES     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_IV_LEN_BYTES      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_IV_TX_LEN_BYTES   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_WINDOW_SIZE       = 3'd4;
  localparam logic [INDEX_W-1:0] REG_IV_FULL_CHECK     = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SEQ_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IV_FAIL  = 2'd2;

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  typedef struct packed {
    logic                seq_field_present;
    logic [LEN_W-1:0]    seq_len_bytes;
    logic [LEN_W-1:0]    iv_len_bytes;
    logic [LEN_W-1:0]    iv_tx_len_bytes;
    logic [WINDOW_W-1:0] window_size;
    logic                iv_full_check;
  } cfg_t;

endpackage

// ----- hdl/arwc_cfg_regs.sv -----
module arwc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [arwc_pkg::INDEX_W-1:0] cfg_index,
  input  logic [arwc_pkg::CFG_W-1:0]   cfg_data,
  output arwc_pkg::cfg_t               cfg
);
  import arwc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq_field_present <= 1'b0;
      cfg.seq_len_bytes     <= 4'd4;
      cfg.iv_len_bytes      <= 4'd12;
      cfg.iv_tx_len_bytes   <= 4'd12;
      cfg.window_size       <= '0;
      cfg.iv_full_check     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEQ_FIELD_PRESENT: cfg.seq_field_present <= cfg_data[0];
        REG_SEQ_LEN_BYTES:     cfg.seq_len_bytes     <= cfg_data[LEN_W-1:0];
        REG_IV_LEN_BYTES:      cfg.iv_len_bytes      <= cfg_data[LEN_W-1:0];
        REG_IV_TX_LEN_BYTES:   cfg.iv_tx_len_bytes   <= cfg_data[LEN_W-1:0];
        REG_WINDOW_SIZE:       cfg.window_size       <= cfg_data[WINDOW_W-1:0];
        REG_IV_FULL_CHECK:     cfg.iv_full_check     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/arwc_check.sv -----
module arwc_check #(
  parameter int MAX_COUNTER_BYTES = 12
) (
  input  arwc_pkg::cfg_t                cfg,
  input  logic                          req_type,
  input  logic [arwc_pkg::LOW_W-1:0]    rx_low,
  input  logic [arwc_pkg::HIGH_W-1:0]   rx_high,
  input  logic [arwc_pkg::LOW_W-1:0]    stored_low,
  input  logic [arwc_pkg::HIGH_W-1:0]   stored_high,
  output logic [arwc_pkg::STATUS_W-1:0] status,
  output logic [arwc_pkg::LOW_W-1:0]    stored_low_next,
  output logic [arwc_pkg::HIGH_W-1:0]   stored_high_next
);
  import arwc_pkg::*;

  localparam int CAP = (MAX_COUNTER_BYTES < CTR_BYTES) ? MAX_COUNTER_BYTES : CTR_BYTES;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

  logic [LEN_W-1:0] iv_part_len;
  logic [LEN_W-1:0] raw_len;
  logic [LEN_W-1:0] len;
  logic [CTR_W-1:0] mask;
  logic [CTR_W-1:0] rx_val;
  logic [CTR_W-1:0] st_val;
  logic [CTR_W-1:0] a_val;
  logic [CTR_W-1:0] s_val;
  logic [CTR_W-1:0] diff;
  logic [CTR_W-1:0] merged;
  logic             both_zero;
  logic             cover_all;
  logic             in_window;
  logic             ok;
  logic             check_on;

  assign rx_val = {rx_high, rx_low};
  assign st_val = {stored_high, stored_low};

  // check length from the mode
  always_comb begin
    iv_part_len = (cfg.iv_tx_len_bytes > cfg.iv_len_bytes) ? cfg.iv_len_bytes
                                                           : cfg.iv_tx_len_bytes;
    if (cfg.seq_field_present) begin
      raw_len = cfg.seq_len_bytes;
    end else if (cfg.iv_full_check) begin
      raw_len = cfg.iv_len_bytes;
    end else begin
      raw_len = iv_part_len;
    end
    len      = (raw_len > CAP_LEN) ? CAP_LEN : raw_len;
    check_on = cfg.seq_field_present || (cfg.iv_len_bytes != '0);
  end

  always_comb begin
    for (int i = 0; i < CTR_BYTES; i++) begin
      mask[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
    end
  end

  assign a_val     = rx_val & mask;
  assign s_val     = st_val & mask;
  assign diff      = (a_val - s_val) & mask;
  assign both_zero = (a_val == '0) && (s_val == '0);
  assign cover_all = (len == 4'd1) && (cfg.window_size[WINDOW_W-1:8] != '0);
  assign in_window = (diff != '0) && (diff <= {{(CTR_W-WINDOW_W){1'b0}}, cfg.window_size});
  assign ok        = both_zero || cover_all || in_window;
  assign merged    = (st_val & ~mask) | a_val;

  always_comb begin
    status           = STATUS_OK;
    stored_low_next  = stored_low;
    stored_high_next = stored_high;
    if (req_type == REQ_LOAD) begin
      stored_low_next  = rx_low;
      stored_high_next = rx_high;
    end else if (check_on) begin
      if (ok) begin
        stored_low_next  = merged[LOW_W-1:0];
        stored_high_next = merged[CTR_W-1:LOW_W];
      end else if (cfg.seq_field_present) begin
        status = STATUS_SEQ_FAIL;
      end else begin
        status = STATUS_IV_FAIL;
      end
    end
  end

endmodule

// ----- hdl/anti_replay_window_check_core.sv -----
// Anti-replay window check for one security association. Each transfer on the
// item channel either loads the 96-bit stored counter (req_type 1) or checks
// rx_high:rx_low against it over L bytes chosen by the mode registers, and
// gives one status transfer per item: 0 accepted or loaded, 1 sequence number
// outside the window, 2 IV outside the window. The item sits in an input register,
// then the masked 96-bit subtract and window compare write the stored counter and
// the result register at the same edge; the status is valid from that register.
// A new item is taken every cycle unless item_stall is high; the next item always
// sees the counter left by the one before. Configuration writes belong to idle
// periods only.
module anti_replay_window_check_core #(
  parameter int MAX_COUNTER_BYTES = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [arwc_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [arwc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          req_type,
  input  logic [arwc_pkg::LOW_W-1:0]    rx_low,
  input  logic [arwc_pkg::HIGH_W-1:0]   rx_high,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [arwc_pkg::STATUS_W-1:0] status
);
  import arwc_pkg::*;

  cfg_t                cfg;
  logic                s1_valid;
  logic                s1_req_type;
  logic [LOW_W-1:0]    s1_rx_low;
  logic [HIGH_W-1:0]   s1_rx_high;
  logic                s1_adv;
  logic                item_take;
  logic [LOW_W-1:0]    stored_low;
  logic [HIGH_W-1:0]   stored_high;
  logic [LOW_W-1:0]    stored_low_next;
  logic [HIGH_W-1:0]   stored_high_next;
  logic [STATUS_W-1:0] chk_status;

  arwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arwc_check #(
    .MAX_COUNTER_BYTES (MAX_COUNTER_BYTES)
  ) u_check (
    .cfg              (cfg),
    .req_type         (s1_req_type),
    .rx_low           (s1_rx_low),
    .rx_high          (s1_rx_high),
    .stored_low       (stored_low),
    .stored_high      (stored_high),
    .status           (chk_status),
    .stored_low_next  (stored_low_next),
    .stored_high_next (stored_high_next)
  );

  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign item_take  = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_req_type <= req_type;
      s1_rx_low   <= rx_low;
      s1_rx_high  <= rx_high;
    end
  end

  // stored counter
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_low  <= '0;
      stored_high <= '0;
    end else if (s1_adv) begin
      stored_low  <= stored_low_next;
      stored_high <= stored_high_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status <= chk_status;
    end
  end

  a_load_ok : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_req_type == REQ_LOAD) |=> (status == STATUS_OK))
    else $error("load transfer did not report ok");

  a_fail_keeps_counter : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && chk_status != STATUS_OK) |=> ($stable(stored_low) && $stable(stored_high)))
    else $error("rejected value changed the counter");

  a_idle_keeps_counter : assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> ($stable(stored_low) && $stable(stored_high)))
    else $error("counter changed without an item");

  a_adv_gives_result : assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("result lost after check");

  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("item stall without a full pipeline");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import arwc_pkg::*;

  typedef struct packed {
    logic              req;
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
  } rx_item_t;

  localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int COUNTER_CAP = 12;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic req_type = REQ_CHECK;
  logic [LOW_W-1:0] rx_low = '0;
  logic [HIGH_W-1:0] rx_high = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [STATUS_W-1:0] status;

  anti_replay_window_check_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .req_type(req_type),
    .rx_low(rx_low),
    .rx_high(rx_high),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow and counter as the block should hold them
  cfg_t shadow = '{1'b0, 4'd4, 4'd12, 4'd12, 16'd0, 1'b1};
  logic [CTR_W-1:0] counter_now = '0;
  logic [CTR_W-1:0] gen_ctr = '0;

  rx_item_t pending_items[$];
  logic [STATUS_W-1:0] expected_status[$];

  int errors = 0;
  int n_accepted = 0;
  int n_settings = 0;
  int input_stall_cycles = 0;
  int status_count[3] = '{0, 0, 0};

  function automatic int clamp_len(input logic [LEN_W-1:0] len);
    return (len > COUNTER_CAP) ? COUNTER_CAP : int'(len);
  endfunction

  function automatic int check_len(input cfg_t c);
    if (c.seq_field_present)
      return clamp_len(c.seq_len_bytes);
    if (c.iv_len_bytes == 0)
      return 0;
    if (c.iv_full_check)
      return clamp_len(c.iv_len_bytes);
    return clamp_len((c.iv_tx_len_bytes > c.iv_len_bytes) ? c.iv_len_bytes
                                                          : c.iv_tx_len_bytes);
  endfunction

  function automatic logic [CTR_W-1:0] byte_mask(input int nbytes);
    if (nbytes >= COUNTER_CAP)
      return '1;
    return ({{(CTR_W-1){1'b0}}, 1'b1} << (8 * nbytes)) - 1;
  endfunction

  // window compare over the low nbytes; moves the counter on acceptance
  function automatic logic advance_counter(input int nbytes, input logic [CTR_W-1:0] rx);
    logic [CTR_W-1:0] mask;
    logic [CTR_W-1:0] fresh;
    logic [CTR_W-1:0] held;
    logic [CTR_W-1:0] delta;
    logic ok;
    if (nbytes == 0)
      return 1'b1;
    mask = byte_mask(nbytes);
    fresh = rx & mask;
    held = counter_now & mask;
    delta = (fresh - held) & mask;
    if (fresh == 0 && held == 0)
      ok = 1'b1;
    else if (nbytes <= 2 && (shadow.window_size >> (8 * nbytes)) != 0)
      ok = 1'b1;
    else
      ok = (delta != 0) && (delta <= {{(CTR_W-WINDOW_W){1'b0}}, shadow.window_size});
    if (ok)
      counter_now = (counter_now & ~mask) | fresh;
    return ok;
  endfunction

  function automatic logic [STATUS_W-1:0] predict_status(input rx_item_t it);
    if (it.req == REQ_LOAD) begin
      counter_now = {it.hi, it.lo};
      return STATUS_OK;
    end
    if (shadow.seq_field_present) begin
      if (!advance_counter(check_len(shadow), {it.hi, it.lo}))
        return STATUS_SEQ_FAIL;
    end else if (shadow.iv_len_bytes != 0) begin
      if (!advance_counter(check_len(shadow), {it.hi, it.lo}))
        return STATUS_IV_FAIL;
    end
    return STATUS_OK;
  endfunction

  function automatic logic [CTR_W-1:0] rand_ctr();
    return {$urandom, $urandom, $urandom};
  endfunction

  // mostly in-window steps from the running counter, plus replays and junk
  function automatic rx_item_t gen_item();
    rx_item_t it;
    logic [CTR_W-1:0] mask;
    logic [CTR_W-1:0] step;
    logic [CTR_W-1:0] sum;
    logic [CTR_W-1:0] val;
    logic [WINDOW_W-1:0] w;
    int r;
    mask = byte_mask(check_len(shadow));
    w = shadow.window_size;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0: val = rand_ctr();
        1: val = ((mask - $urandom_range(0, 8)) & mask) | (rand_ctr() & ~mask);
        default: val = '0;
      endcase
      gen_ctr = val;
      it.req = REQ_LOAD;
    end else begin
      if (r < 70) begin
        if (w == 0)
          step = '0;
        else if ($urandom_range(0, 2) == 0)
          step = $urandom_range(1, (w < 8) ? w : 8);
        else if ($urandom_range(0, 3) == 0)
          step = w;
        else
          step = $urandom_range(1, w);
      end else if (r < 80)
        step = '0;
      else if (r < 88)
        step = w + 1;
      else if (r < 94)
        step = '0 - $urandom_range(1, 16);
      else
        step = rand_ctr() - gen_ctr;
      sum = gen_ctr + step;
      if ($urandom_range(0, 1) == 0)
        val = (sum & mask) | (rand_ctr() & ~mask);
      else
        val = (sum & mask) | (gen_ctr & ~mask);
      if (r < 70 && step != 0)
        gen_ctr = (gen_ctr & ~mask) | (sum & mask);
      it.req = REQ_CHECK;
    end
    it.hi = val[CTR_W-1:LOW_W];
    it.lo = val[LOW_W-1:0];
    return it;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1, 2: return 4'd12;
      3: return 4'd15;
      4: return LEN_W'($urandom_range(13, 15));
      5: return 4'd1;
      6: return 4'd2;
      default: return LEN_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.seq_field_present = 1'($urandom_range(0, 1));
    c.seq_len_bytes = pick_len();
    c.iv_len_bytes = ($urandom_range(0, 9) == 0) ? 4'd0 : pick_len();
    c.iv_tx_len_bytes = pick_len();
    c.iv_full_check = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: c.window_size = 16'd0;
      1: c.window_size = 16'hFFFF;
      2: c.window_size = 16'd1;
      3: c.window_size = 16'd256;
      default: c.window_size = WINDOW_W'($urandom_range(1, 4096));
    endcase
    return c;
  endfunction

  function automatic cfg_t make_cfg(input logic sp, input logic [LEN_W-1:0] sl,
                                    input logic [LEN_W-1:0] il, input logic [LEN_W-1:0] tl,
                                    input logic [WINDOW_W-1:0] w, input logic full);
    cfg_t c;
    c.seq_field_present = sp;
    c.seq_len_bytes = sl;
    c.iv_len_bytes = il;
    c.iv_tx_len_bytes = tl;
    c.window_size = w;
    c.iv_full_check = full;
    return c;
  endfunction

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value,
                           input logic [CFG_W-1:0] field_mask);
    logic [CFG_W-1:0] junk;
    logic [CFG_W-1:0] data;
    junk = CFG_W'($urandom);
    data = (junk & ~field_mask) | (value & field_mask);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SEQ_FIELD_PRESENT: shadow.seq_field_present = data[0];
      REG_SEQ_LEN_BYTES: shadow.seq_len_bytes = data[LEN_W-1:0];
      REG_IV_LEN_BYTES: shadow.iv_len_bytes = data[LEN_W-1:0];
      REG_IV_TX_LEN_BYTES: shadow.iv_tx_len_bytes = data[LEN_W-1:0];
      REG_WINDOW_SIZE: shadow.window_size = data[WINDOW_W-1:0];
      REG_IV_FULL_CHECK: shadow.iv_full_check = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(REG_SPARE_LO, '0, '0);
    write_reg(REG_SEQ_FIELD_PRESENT, c.seq_field_present, 16'h0001);
    write_reg(REG_SEQ_LEN_BYTES, c.seq_len_bytes, 16'h000F);
    write_reg(REG_IV_LEN_BYTES, c.iv_len_bytes, 16'h000F);
    write_reg(REG_IV_TX_LEN_BYTES, c.iv_tx_len_bytes, 16'h000F);
    write_reg(REG_WINDOW_SIZE, c.window_size, 16'hFFFF);
    write_reg(REG_IV_FULL_CHECK, c.iv_full_check, 16'h0001);
    write_reg(REG_SPARE_HI, '0, '0);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send(input logic req, input logic [LOW_W-1:0] lo, input logic [HIGH_W-1:0] hi);
    rx_item_t it;
    it.req = req;
    it.lo = lo;
    it.hi = hi;
    pending_items.push_back(it);
  endtask

  // wait until nothing is queued, offered or outstanding
  task automatic settle();
    do
      @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  rx_item_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        item_valid <= 1'b1;
        req_type <= nxt.req;
        rx_low <= nxt.lo;
        rx_high <= nxt.hi;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own, plus two long hold-offs
  int hold_left = 0;
  int holds_done = 0;
  int mode_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && n_accepted >= ((holds_done == 0) ? 300 : 900)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= !result_stall;
        endcase
      end
    end
  end

  // item transfers feed the predictor, status transfers are checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_stall)
        input_stall_cycles <= input_stall_cycles + 1;
      if (item_valid && !item_stall) begin
        expected_status.push_back(predict_status('{req_type, rx_low, rx_high}));
        n_accepted <= n_accepted + 1;
      end
      if (result_valid && !result_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: status transfer %0d with nothing expected", $time, status);
          errors++;
        end else begin
          if (status !== expected_status[0]) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, expected_status[0], status);
            errors++;
          end else if (status < 3) begin
            status_count[status]++;
          end
          void'(expected_status.pop_front());
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full 96-bit IV check, zero window
    send(REQ_CHECK, 64'd0, 32'd0);
    send(REQ_CHECK, 64'd5, 32'd0);
    send(REQ_LOAD, '1, '1);
    send(REQ_CHECK, '1, '1);
    settle();

    // 4-byte sequence number, widest window, wrap with upper bytes kept
    set_config(make_cfg(1'b1, 4'd4, 4'd12, 4'd12, 16'hFFFF, 1'b1));
    send(REQ_LOAD, 64'd0, 32'd0);
    send(REQ_CHECK, 64'd1, 32'd0);
    send(REQ_CHECK, 64'h1_0000, 32'd0);
    send(REQ_CHECK, 64'h2_0001, 32'd0);
    send(REQ_LOAD, 64'hAAAA_5555_FFFF_FFF0, 32'h1234_5678);
    send(REQ_CHECK, 64'h5, 32'hFFFF_FFFF);
    send(REQ_CHECK, 64'h5, 32'hFFFF_FFFF);
    settle();

    // zero length, then oversized length saturating at 12 bytes
    set_config(make_cfg(1'b1, 4'd0, 4'd12, 4'd12, 16'd3, 1'b1));
    send(REQ_CHECK, 64'h0123_4567_89AB_CDEF, 32'h7654_3210);
    settle();
    set_config(make_cfg(1'b1, 4'd15, 4'd12, 4'd12, 16'hFFFF, 1'b1));
    send(REQ_LOAD, '1, '1);
    send(REQ_CHECK, 64'd0, 32'd0);
    send(REQ_CHECK, 64'd0, 32'd0);
    settle();

    // one-byte check with a window covering every value, then two bytes
    set_config(make_cfg(1'b1, 4'd1, 4'd12, 4'd12, 16'd256, 1'b1));
    send(REQ_LOAD, 64'h77, 32'd0);
    send(REQ_CHECK, 64'h77, 32'd0);
    settle();
    set_config(make_cfg(1'b1, 4'd2, 4'd12, 4'd12, 16'hFFFF, 1'b1));
    send(REQ_CHECK, 64'h77, 32'd0);
    send(REQ_CHECK, 64'h76, 32'd0);
    settle();

    // IV mode: disabled, partial length cut to full length, short partial
    set_config(make_cfg(1'b0, 4'd4, 4'd0, 4'd12, 16'd0, 1'b1));
    send(REQ_CHECK, 64'd123, 32'd9);
    settle();
    set_config(make_cfg(1'b0, 4'd4, 4'd8, 4'd12, 16'd10, 1'b0));
    send(REQ_LOAD, 64'd0, 32'd0);
    send(REQ_CHECK, 64'd3, 32'hFFFF_FFFF);
    send(REQ_CHECK, 64'd2, 32'd0);
    settle();
    set_config(make_cfg(1'b0, 4'd4, 4'd12, 4'd3, 16'd1, 1'b0));
    send(REQ_LOAD, 64'h00FF_FFFF, 32'hDEAD_BEEF);
    send(REQ_CHECK, 64'd0, 32'd0);
    send(REQ_CHECK, 64'd0, 32'd0);
    send(REQ_CHECK, 64'd2, 32'd0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(random_cfg());
      gen_ctr = counter_now;
      repeat (PHASE_ITEMS) pending_items.push_back(gen_item());
      settle();
    end

    repeat (6) @(posedge clk);
    $display("%0d items over %0d register settings, %0d input stall cycles",
             n_accepted, n_settings, input_stall_cycles);
    $display("status seen: %0d accepted or loaded, %0d sequence rejects, %0d IV rejects",
             status_count[0], status_count[1], status_count[2]);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/arwc_pkg.sv
hdl/arwc_cfg_regs.sv
hdl/arwc_check.sv
hdl/anti_replay_window_check_core.sv
tb/sv/testbench.sv
